@@ rtl/core/gshm_pkg.sv @@
// Shared types and constants for the generational handle slot map.
package gshm_pkg;

    localparam int unsigned SLOTS_DEF = 256;
    localparam int unsigned HIDX_W    = 24;
    localparam int unsigned GEN_W     = 8;
    localparam int unsigned SIDX_W    = 8;
    localparam int unsigned LIVE_W    = 9;

    localparam logic [GEN_W-1:0] GEN_START = 8'd1;

    typedef enum logic [1:0] {
        FN_ALLOC  = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_FREE   = 2'd2,
        FN_RSVD   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_CHECK
    } t_state;

endpackage

@@ rtl/core/gshm_req_if.sv @@
// Request channel: operation code and handle.
interface gshm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] handle_in;

    modport source (output valid, output func, output handle_in, input ready);
    modport sink   (input valid, input func, input handle_in, output ready);
endinterface

@@ rtl/core/gshm_rsp_if.sv @@
// Response channel: status, new handle, slot index and live count.
interface gshm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [7:0]  slot_index;
    logic [8:0]  live_count;

    modport source (output valid, output status, output handle_out, output slot_index,
                    output live_count, input ready);
    modport sink   (input valid, input status, input handle_out, input slot_index,
                    input live_count, output ready);
endinterface

@@ rtl/core/generational_handle_slot_map_core.sv @@
// Generational handle slot map: top level with slot and free-stack memories.
//
// Channels: i_req takes one word {func, handle_in}; o_rsp returns one word
// {status, handle_out, slot_index, live_count} for every request, in order.
// func 0 allocates a slot, 1 checks a handle, 2 frees a handle.
//
// Timing: a look-up or free reads the slot memory in the cycle that it is
// taken, and its response is registered from S_CHECK once the output register
// is free. An allocate first reads the free-index stack, then (in S_POP) the
// slot memory at the popped index; a full allocate skips the slot read.
// These reads of the two memories, one after the other, set the rate.
// i_req.ready is high only between words.
//
// Reset: the slot memory (generation 1, not occupied) and the free stack
// (entry i holds SLOTS-1-i) are rewritten one entry per cycle in S_CLEAR,
// during which no request is taken.
//
// Stall: the response register holds while o_rsp.ready is low; the next
// request is still taken and finishes its memory reads, then waits at the
// write-back step until the register drains.
module generational_handle_slot_map_core #(
    parameter int unsigned SLOTS = gshm_pkg::SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gshm_req_if.sink   i_req,
    gshm_rsp_if.source o_rsp
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned GW = gshm_pkg::GEN_W;
    localparam int unsigned HW = gshm_pkg::HIDX_W;

    // slot memory word: {occupied, generation}
    logic [GW:0]   m_slot [SLOTS];
    logic [IW-1:0] m_stk  [SLOTS];

    gshm_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_clr_addr;
    logic [CW-1:0] r_free_depth, n_free_depth;
    logic [CW-1:0] r_occ_total, n_occ_total;

    gshm_pkg::t_func r_func;
    logic [GW-1:0]   r_hgen;
    logic            r_pre_ok;
    logic [IW-1:0]   r_idx;
    logic [GW:0]     r_slot_q;
    logic [IW-1:0]   r_stk_q;

    logic                     r_out_valid;
    gshm_pkg::t_status        r_status, n_status;
    logic [31:0]              r_handle_out, n_handle_out;
    logic [gshm_pkg::SIDX_W-1:0] r_slot_index, n_slot_index;
    logic [gshm_pkg::LIVE_W-1:0] r_live_count;

    // control produced by the output block
    logic          req_take;
    logic          out_load;
    logic          slot_rd_en;
    logic [IW-1:0] slot_rd_addr;
    logic          stk_rd_en;
    logic [IW-1:0] stk_rd_addr;
    logic          slot_wr_en;
    logic [IW-1:0] slot_wr_addr;
    logic [GW:0]   slot_wr_data;
    logic          stk_wr_en;
    logic [IW-1:0] stk_wr_addr;
    logic [IW-1:0] stk_wr_data;

    gshm_pkg::t_func in_func;
    logic [HW-1:0]   in_hidx;
    logic            in_hok;
    logic            slot_hit;
    logic [GW-1:0]   gen_inc;
    logic [GW-1:0]   gen_next;

    assign in_func  = gshm_pkg::t_func'(i_req.func);
    assign in_hidx  = i_req.handle_in[HW-1:0];
    assign in_hok   = (i_req.handle_in != 32'd0) && ((HW + 1)'(in_hidx) < (HW + 1)'(SLOTS));
    assign slot_hit = r_pre_ok && r_slot_q[GW] && (r_slot_q[GW-1:0] == r_hgen);
    assign gen_inc  = r_slot_q[GW-1:0] + GW'(1);
    assign gen_next = (gen_inc == '0) ? gshm_pkg::GEN_START : gen_inc;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gshm_pkg::S_CLEAR: begin
                if (r_clr_addr == IW'(SLOTS - 1)) n_state = gshm_pkg::S_IDLE;
            end
            gshm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    if (in_func == gshm_pkg::FN_ALLOC && r_free_depth != '0)
                        n_state = gshm_pkg::S_POP;
                    else
                        n_state = gshm_pkg::S_CHECK;
                end
            end
            gshm_pkg::S_POP:   n_state = gshm_pkg::S_CHECK;
            gshm_pkg::S_CHECK: begin
                if (!r_out_valid || o_rsp.ready) n_state = gshm_pkg::S_IDLE;
            end
            default: n_state = gshm_pkg::S_CLEAR;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        req_take     = 1'b0;
        out_load     = 1'b0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = in_hidx[IW-1:0];
        stk_rd_en    = 1'b0;
        stk_rd_addr  = IW'(r_free_depth - CW'(1));
        slot_wr_en   = 1'b0;
        slot_wr_addr = r_idx;
        slot_wr_data = r_slot_q;
        stk_wr_en    = 1'b0;
        stk_wr_addr  = IW'(r_free_depth);
        stk_wr_data  = r_idx;
        n_free_depth = r_free_depth;
        n_occ_total  = r_occ_total;
        n_status     = gshm_pkg::ST_BAD;
        n_handle_out = 32'd0;
        n_slot_index = '0;
        case (r_state)
            gshm_pkg::S_CLEAR: begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = r_clr_addr;
                slot_wr_data = {1'b0, gshm_pkg::GEN_START};
                stk_wr_en    = 1'b1;
                stk_wr_addr  = r_clr_addr;
                stk_wr_data  = IW'(SLOTS - 1) - r_clr_addr;
            end
            gshm_pkg::S_IDLE: begin
                req_take   = i_req.valid;
                slot_rd_en = i_req.valid && in_func != gshm_pkg::FN_ALLOC;
                stk_rd_en  = i_req.valid && in_func == gshm_pkg::FN_ALLOC;
            end
            gshm_pkg::S_POP: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = r_stk_q;
            end
            gshm_pkg::S_CHECK: begin
                out_load = !r_out_valid || o_rsp.ready;
                case (r_func)
                    gshm_pkg::FN_ALLOC: begin
                        if (r_pre_ok) begin
                            n_status     = gshm_pkg::ST_OK;
                            n_handle_out = {r_slot_q[GW-1:0], HW'(r_idx)};
                            n_slot_index = gshm_pkg::SIDX_W'(r_idx);
                            slot_wr_en   = out_load;
                            slot_wr_data = {1'b1, r_slot_q[GW-1:0]};
                            n_free_depth = r_free_depth - CW'(1);
                            n_occ_total  = r_occ_total + CW'(1);
                        end else begin
                            n_status = gshm_pkg::ST_FULL;
                        end
                    end
                    gshm_pkg::FN_LOOKUP: begin
                        if (slot_hit) begin
                            n_status     = gshm_pkg::ST_OK;
                            n_slot_index = gshm_pkg::SIDX_W'(r_idx);
                        end
                    end
                    gshm_pkg::FN_FREE: begin
                        if (slot_hit) begin
                            n_status     = gshm_pkg::ST_OK;
                            n_slot_index = gshm_pkg::SIDX_W'(r_idx);
                            slot_wr_en   = out_load;
                            slot_wr_data = {1'b0, gen_next};
                            if (r_free_depth < CW'(SLOTS)) begin
                                stk_wr_en    = out_load;
                                n_free_depth = r_free_depth + CW'(1);
                            end
                            if (r_occ_total != '0) n_occ_total = r_occ_total - CW'(1);
                        end
                    end
                    default: begin
                        n_status = gshm_pkg::ST_BAD;
                    end
                endcase
            end
            default: begin
                req_take = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_state == gshm_pkg::S_IDLE);

    // memories
    always_ff @(posedge i_clk) begin
        if (slot_wr_en) m_slot[slot_wr_addr] <= slot_wr_data;
        if (slot_rd_en) r_slot_q <= m_slot[slot_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_wr_en) m_stk[stk_wr_addr] <= stk_wr_data;
        if (stk_rd_en) r_stk_q <= m_stk[stk_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gshm_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_free_depth <= CW'(SLOTS);
            r_occ_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == gshm_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + IW'(1);
            if (out_load) begin
                r_free_depth <= n_free_depth;
                r_occ_total  <= n_occ_total;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and response payload
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_func   <= in_func;
            r_hgen   <= i_req.handle_in[31:HW];
            r_idx    <= in_hidx[IW-1:0];
            r_pre_ok <= (in_func == gshm_pkg::FN_ALLOC) ? (r_free_depth != '0) : in_hok;
        end
        if (r_state == gshm_pkg::S_POP) r_idx <= r_stk_q;
        if (out_load) begin
            r_status     <= n_status;
            r_handle_out <= n_handle_out;
            r_slot_index <= n_slot_index;
            r_live_count <= gshm_pkg::LIVE_W'(n_occ_total);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.handle_out = r_handle_out;
    assign o_rsp.slot_index = r_slot_index;
    assign o_rsp.live_count = r_live_count;

endmodule

@@ dv/generational_handle_slot_map_core_tb.sv @@
// Self-checking testbench for the generational handle slot map core.
module generational_handle_slot_map_core_tb;

    localparam int unsigned NSLOTS         = gshm_pkg::SLOTS_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 20;

    typedef struct packed {
        gshm_pkg::t_func fn;
        logic [31:0]     handle;
    } t_slot_req;

    typedef struct packed {
        gshm_pkg::t_status                status;
        logic [31:0]                      handle;
        logic [gshm_pkg::SIDX_W-1:0]      slot;
        logic [gshm_pkg::LIVE_W-1:0]      live;
    } t_slot_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gshm_req_if req_ch ();
    gshm_rsp_if rsp_ch ();

    generational_handle_slot_map_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted slot map contents
    logic [gshm_pkg::GEN_W-1:0] generation [NSLOTS];
    bit                         occupied   [NSLOTS];
    int unsigned                free_lifo  [NSLOTS];
    int unsigned                free_top;
    int unsigned                live_total;

    t_slot_req   req_q[$];
    t_slot_rsp   rsp_expect_q[$];
    int unsigned pushed_cnt  = 0;
    int unsigned taken_cnt   = 0;
    int unsigned errors      = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          req_taken   = 1'b0;

    function automatic t_slot_rsp slot_map_step(gshm_pkg::t_func fn, logic [31:0] h);
        t_slot_rsp   r;
        int unsigned idx;
        bit          known;
        r = '{status: gshm_pkg::ST_BAD, handle: '0, slot: '0, live: '0};
        idx = h[gshm_pkg::HIDX_W-1:0];
        known = (h != 0) && (idx < NSLOTS) && occupied[idx] &&
                (generation[idx] == h[31:gshm_pkg::HIDX_W]);
        case (fn)
            gshm_pkg::FN_ALLOC: begin
                if (free_top == 0) begin
                    r.status = gshm_pkg::ST_FULL;
                end else begin
                    free_top--;
                    idx = free_lifo[free_top];
                    occupied[idx] = 1'b1;
                    live_total++;
                    r.status = gshm_pkg::ST_OK;
                    r.handle = {generation[idx], gshm_pkg::HIDX_W'(idx)};
                    r.slot   = gshm_pkg::SIDX_W'(idx);
                end
            end
            gshm_pkg::FN_LOOKUP: begin
                if (known) begin
                    r.status = gshm_pkg::ST_OK;
                    r.slot   = gshm_pkg::SIDX_W'(idx);
                end
            end
            gshm_pkg::FN_FREE: begin
                if (known) begin
                    occupied[idx] = 1'b0;
                    generation[idx] = generation[idx] + 1'b1;
                    if (generation[idx] == 0)
                        generation[idx] = gshm_pkg::GEN_START;
                    if (free_top < NSLOTS) begin
                        free_lifo[free_top] = idx;
                        free_top++;
                    end
                    if (live_total > 0)
                        live_total--;
                    r.status = gshm_pkg::ST_OK;
                    r.slot   = gshm_pkg::SIDX_W'(idx);
                end
            end
            default: ;
        endcase
        r.live = gshm_pkg::LIVE_W'(live_total);
        return r;
    endfunction

    // Sender: new word at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        t_slot_req item;
        if (!i_rst_n) begin
            req_ch.valid  <= 1'b0;
            rsp_ch.ready  <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (req_ch.valid && !req_taken) begin
                // hold the word until taken
            end else if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = req_q.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.func      <= item.fn;
                req_ch.handle_in <= item.handle;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on request, check on response
    always @(posedge i_clk) begin
        t_slot_rsp want;
        bit        req_fire;
        bit        rsp_fire;
        req_fire = i_rst_n && req_ch.valid && req_ch.ready;
        rsp_fire = i_rst_n && rsp_ch.valid && rsp_ch.ready;
        req_taken <= req_fire;
        if (req_fire) begin
            rsp_expect_q.push_back(slot_map_step(gshm_pkg::t_func'(req_ch.func),
                                                 req_ch.handle_in));
            taken_cnt <= taken_cnt + 1;
        end
        if (rsp_fire) begin
            if (rsp_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected response: status %0d handle %h slot %0d live %0d",
                         $time, rsp_ch.status, rsp_ch.handle_out, rsp_ch.slot_index,
                         rsp_ch.live_count);
            end else begin
                want = rsp_expect_q.pop_front();
                if ({rsp_ch.status, rsp_ch.handle_out, rsp_ch.slot_index, rsp_ch.live_count}
                        !== want) begin
                    errors++;
                    $display("%0t: mismatch: expected status %0d handle %h slot %0d live %0d",
                             $time, want.status, want.handle, want.slot, want.live);
                    $display("%0t:           got status %0d handle %h slot %0d live %0d",
                             $time, rsp_ch.status, rsp_ch.handle_out, rsp_ch.slot_index,
                             rsp_ch.live_count);
                end
            end
        end
        quiet_cycles <= (req_fire || rsp_fire) ? 0 : quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("generational_handle_slot_map_core_tb failed");
            $finish;
        end
    end

    task automatic push_req(gshm_pkg::t_func fn, logic [31:0] h);
        req_q.push_back('{fn: fn, handle: h});
        pushed_cnt++;
    endtask

    // Wait until every queued word has been taken, so the prediction is current
    task automatic wait_taken();
        @(posedge i_clk);
        while (taken_cnt != pushed_cnt)
            @(posedge i_clk);
    endtask

    function automatic bit live_handle(output logic [31:0] h);
        int unsigned s;
        h = '0;
        if (live_total == 0)
            return 1'b0;
        s = $urandom_range(0, NSLOTS - 1);
        repeat (NSLOTS) begin
            if (occupied[s]) begin
                h = {generation[s], gshm_pkg::HIDX_W'(s)};
                return 1'b1;
            end
            s = (s + 1) % NSLOTS;
        end
        return 1'b0;
    endfunction

    // Handles that should be refused, plus the odd one that happens to be live
    function automatic logic [31:0] odd_handle();
        int unsigned s;
        s = $urandom_range(0, NSLOTS - 1);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return {gshm_pkg::GEN_W'($urandom),
                       gshm_pkg::HIDX_W'($urandom_range(NSLOTS,
                                                        (1 << gshm_pkg::HIDX_W) - 1))};
            2: return $urandom;
            3: return {generation[s] + gshm_pkg::GEN_W'($urandom_range(1, 255)),
                       gshm_pkg::HIDX_W'(s)};
            default: return {generation[s], gshm_pkg::HIDX_W'(s)};
        endcase
    endfunction

    task automatic mixed_ops(int unsigned n);
        int unsigned r;
        logic [31:0] h;
        repeat (n) begin
            while (req_q.size() > 1)
                @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (!($urandom_range(0, 99) < 80 && live_handle(h)))
                h = odd_handle();
            if (r < 35)
                push_req(gshm_pkg::FN_ALLOC, $urandom);
            else if (r < 65)
                push_req(gshm_pkg::FN_LOOKUP, h);
            else if (r < 92)
                push_req(gshm_pkg::FN_FREE, h);
            else
                push_req(gshm_pkg::FN_RSVD, h);
        end
    endtask

    // Allocate past full, then free every slot in random order
    task automatic fill_and_drain();
        int unsigned order[$];
        int unsigned j;
        int unsigned t;
        logic [31:0] h;
        wait_taken();
        repeat (NSLOTS - live_total + 3)
            push_req(gshm_pkg::FN_ALLOC, $urandom);
        repeat (16) begin
            if (live_handle(h))
                push_req(gshm_pkg::FN_LOOKUP, h);
        end
        wait_taken();
        for (int unsigned s = 0; s < NSLOTS; s++)
            if (occupied[s])
                order.push_back(s);
        for (int k = order.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        foreach (order[k])
            push_req(gshm_pkg::FN_FREE,
                     {generation[order[k]], gshm_pkg::HIDX_W'(order[k])});
    endtask

    // Alloc/free the same slot over and over: walks its generation through the wrap
    task automatic churn(int unsigned n);
        int unsigned s;
        logic [31:0] h;
        repeat (n) begin
            wait_taken();
            if (free_top != 0) begin
                s = free_lifo[free_top - 1];
                h = {generation[s], gshm_pkg::HIDX_W'(s)};
                push_req(gshm_pkg::FN_ALLOC, $urandom);
                if ($urandom_range(0, 99) < 30)
                    push_req(gshm_pkg::FN_LOOKUP, h);
                push_req(gshm_pkg::FN_FREE, h);
                if ($urandom_range(0, 99) < 20)
                    push_req(gshm_pkg::FN_LOOKUP, h);
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = gshm_pkg::FN_ALLOC;
        req_ch.handle_in = '0;
        rsp_ch.ready     = 1'b0;
        for (int unsigned s = 0; s < NSLOTS; s++) begin
            generation[s] = gshm_pkg::GEN_START;
            occupied[s]   = 1'b0;
            free_lifo[s]  = NSLOTS - 1 - s;
        end
        free_top   = NSLOTS;
        live_total = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 81;
        // directed: zero, out of range, free and stale slots, unused code
        push_req(gshm_pkg::FN_LOOKUP, 32'h0000_0000);
        push_req(gshm_pkg::FN_FREE,   32'h0000_0000);
        push_req(gshm_pkg::FN_LOOKUP, {gshm_pkg::GEN_START, 24'd0});
        push_req(gshm_pkg::FN_ALLOC,  32'h0000_0000);
        push_req(gshm_pkg::FN_LOOKUP, {gshm_pkg::GEN_START, 24'd0});
        push_req(gshm_pkg::FN_LOOKUP, {8'd2, 24'd0});
        push_req(gshm_pkg::FN_LOOKUP, {gshm_pkg::GEN_START, 24'(NSLOTS)});
        push_req(gshm_pkg::FN_LOOKUP, 32'hFFFF_FFFF);
        push_req(gshm_pkg::FN_LOOKUP, {gshm_pkg::GEN_START, 24'hFF_FFFF});
        push_req(gshm_pkg::FN_RSVD,   {gshm_pkg::GEN_START, 24'd0});
        push_req(gshm_pkg::FN_ALLOC,  32'h0000_0000);
        push_req(gshm_pkg::FN_LOOKUP, {gshm_pkg::GEN_START, 24'd1});
        push_req(gshm_pkg::FN_FREE,   {gshm_pkg::GEN_START, 24'd0});
        push_req(gshm_pkg::FN_FREE,   {gshm_pkg::GEN_START, 24'd0});
        push_req(gshm_pkg::FN_LOOKUP, {8'd2, 24'd0});
        push_req(gshm_pkg::FN_ALLOC,  32'hFFFF_FFFF);
        push_req(gshm_pkg::FN_LOOKUP, {8'd2, 24'd0});
        push_req(gshm_pkg::FN_LOOKUP, {gshm_pkg::GEN_START, 24'd0});
        push_req(gshm_pkg::FN_FREE,   {gshm_pkg::GEN_START, 24'd1});
        push_req(gshm_pkg::FN_FREE,   {8'd2, 24'd0});
        push_req(gshm_pkg::FN_RSVD,   32'hFFFF_FFFF);
        push_req(gshm_pkg::FN_LOOKUP, {8'd0, 24'(NSLOTS - 1)});
        mixed_ops(200);
        fill_and_drain();

        wait_taken();
        send_idle_pct = 81;
        recv_idle_pct = 7;
        churn(256);
        mixed_ops(100);

        wait_taken();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mixed_ops(150);
        wait_taken();
        while (rsp_expect_q.size() != 0)
            @(posedge i_clk);
        mixed_ops(100);

        wait_taken();
        while (rsp_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("generational_handle_slot_map_core_tb passed");
        else
            $display("generational_handle_slot_map_core_tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/gshm_pkg.sv
rtl/core/gshm_req_if.sv
rtl/core/gshm_rsp_if.sv
rtl/core/generational_handle_slot_map_core.sv
dv/generational_handle_slot_map_core_tb.sv
